[hdl/cfga_pkg.sv]
// package for the 3x3 filter gradient accumulator
// shared types, constants and float helper functions; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cfga_pkg;

    localparam int TapCount = 9;
    localparam logic [31:0] QnanBits = 32'h7FC00000;
    localparam logic [31:0] InfBits = 32'h7F800000;

    typedef logic signed [12:0] t_exp;

    typedef struct packed {
        logic        sgn;
        logic        zero;
        logic        inf;
        logic        nan;
        logic [23:0] man;
        t_exp        exp;
    } t_fp_unp;

    typedef struct packed {
        logic load;
        logic commit;
        logic clear;
    } t_lane_ctl;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 5'd1;
                end
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] msb64(input logic [63:0] v);
        logic [5:0] k;
        logic       found;
        k = 6'd0;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && v[i]) begin
                found = 1'b1;
                k = 6'(i);
            end
        end
        return k;
    endfunction

    function automatic t_fp_unp unpack(input logic [31:0] x);
        t_fp_unp    u;
        logic [4:0] sh;
        sh = lzc24({1'b0, x[22:0]});
        u.sgn = x[31];
        u.zero = (x[30:0] == 31'd0);
        u.inf = (x[30:0] == InfBits[30:0]);
        u.nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        if (x[30:23] == 8'd0) begin
            u.man = {1'b0, x[22:0]} << sh;
            u.exp = 13'sd1 - $signed({8'd0, sh});
        end else begin
            u.man = {1'b1, x[22:0]};
            u.exp = $signed({5'd0, x[30:23]});
        end
        return u;
    endfunction

    function automatic logic [63:0] shr_sticky(input logic [63:0] v, input logic [6:0] d);
        logic [63:0] mask;
        mask = (64'd1 << d) - 64'd1;
        if (d >= 7'd63) begin
            return {63'd0, |v};
        end
        return (v >> d) | {63'd0, |(v & mask)};
    endfunction

endpackage
`default_nettype wire

[hdl/cfga_lane.sv]
// one tap lane: fused multiply-add into a single-precision accumulator
// four register stages per item; depends on cfga_pkg
`timescale 1ns / 1ps
`default_nettype none
module cfga_lane (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cfga_pkg::t_lane_ctl i_ctl,
    input  wire logic [31:0]       i_win,
    input  wire logic [31:0]       i_grad,
    output logic [31:0]            o_sum
);

    logic [31:0]        r_acc;
    cfga_pkg::t_fp_unp  r_a, r_b;

    logic [47:0]        r_s1_mp;
    cfga_pkg::t_exp     r_s1_pe;
    logic               r_s1_ps, r_s1_spec, r_s1_czero;
    logic [31:0]        r_s1_sval;

    logic [63:0]        r_s2_r;
    cfga_pkg::t_exp     r_s2_ee;
    logic               r_s2_rs, r_s2_zero, r_s2_spec;
    logic [31:0]        r_s2_sval;

    logic [63:0]        r_s3_r;
    cfga_pkg::t_exp     r_s3_s, r_s3_bexp;
    logic               r_s3_rs, r_s3_zero, r_s3_spec, r_s3_ovf;
    logic [31:0]        r_s3_sval;

    cfga_pkg::t_fp_unp  uc;
    logic               ps, spec;
    logic [31:0]        sval;

    logic [63:0]        mp64, mc64, n_r;
    cfga_pkg::t_exp     ce, diff, n_ee;
    logic [6:0]         dsh;
    logic               n_rs;

    logic [5:0]         k;
    cfga_pkg::t_exp     bexp, n_s;

    cfga_pkg::t_exp     neg_s;
    logic [6:0]         ss;
    logic [63:0]        q, rem, half, res;
    logic [31:0]        result;

    assign uc = cfga_pkg::unpack(r_acc);
    assign ps = r_a.sgn ^ r_b.sgn;

    // special operands
    always_comb begin
        spec = 1'b1;
        sval = cfga_pkg::QnanBits;
        if (r_a.nan || r_b.nan || uc.nan) begin
            sval = cfga_pkg::QnanBits;
        end else if ((r_a.inf && r_b.zero) || (r_b.inf && r_a.zero)) begin
            sval = cfga_pkg::QnanBits;
        end else if (r_a.inf || r_b.inf) begin
            if (uc.inf && (uc.sgn != ps)) begin
                sval = cfga_pkg::QnanBits;
            end else begin
                sval = {ps, cfga_pkg::InfBits[30:0]};
            end
        end else if (uc.inf) begin
            sval = r_acc;
        end else if (r_a.zero || r_b.zero) begin
            if (uc.zero) begin
                sval = {ps & uc.sgn, 31'd0};
            end else begin
                sval = r_acc;
            end
        end else begin
            spec = 1'b0;
        end
    end

    // align and add
    always_comb begin
        mp64 = {1'b0, r_s1_mp, 15'd0};
        mc64 = {2'd0, uc.man, 38'd0};
        ce = uc.exp - 13'sd188;
        diff = r_s1_pe - ce;
        dsh = 7'd0;
        n_ee = r_s1_pe;
        n_rs = r_s1_ps;
        n_r = mp64;
        if (!r_s1_czero) begin
            if (diff >= 13'sd0) begin
                dsh = (diff > 13'sd63) ? 7'd63 : diff[6:0];
                mc64 = cfga_pkg::shr_sticky(mc64, dsh);
            end else begin
                dsh = (-diff > 13'sd63) ? 7'd63 : 7'(-diff);
                mp64 = cfga_pkg::shr_sticky(mp64, dsh);
                n_ee = ce;
            end
            if (r_s1_ps == uc.sgn) begin
                n_r = mp64 + mc64;
            end else if (mp64 >= mc64) begin
                n_r = mp64 - mc64;
            end else begin
                n_r = mc64 - mp64;
                n_rs = uc.sgn;
            end
        end
    end

    // leading one and exponent
    always_comb begin
        k = cfga_pkg::msb64(r_s2_r);
        bexp = $signed({7'd0, k}) + r_s2_ee + 13'sd127;
        if (bexp < 13'sd1) begin
            bexp = 13'sd1;
        end
        n_s = bexp - 13'sd150 - r_s2_ee;
    end

    // round and pack
    always_comb begin
        neg_s = -r_s3_s;
        ss = 7'd0;
        rem = 64'd0;
        half = 64'd0;
        if (r_s3_s <= 13'sd0) begin
            ss = (neg_s > 13'sd40) ? 7'd40 : neg_s[6:0];
            q = r_s3_r << ss;
        end else begin
            ss = (r_s3_s > 13'sd63) ? 7'd63 : r_s3_s[6:0];
            q = r_s3_r >> ss;
            rem = r_s3_r & ((64'd1 << ss) - 64'd1);
            half = 64'd1 << (ss - 7'd1);
            if ((rem > half) || ((rem == half) && q[0])) begin
                q = q + 64'd1;
            end
        end
        res = {33'd0, r_s3_bexp[7:0] - 8'd1, 23'd0} + q;
        if (r_s3_spec) begin
            result = r_s3_sval;
        end else if (r_s3_zero) begin
            result = 32'd0;
        end else if (r_s3_ovf || (res >= {32'd0, cfga_pkg::InfBits})) begin
            result = {r_s3_rs, cfga_pkg::InfBits[30:0]};
        end else begin
            result = {r_s3_rs, res[30:0]};
        end
    end

    assign o_sum = result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 32'd0;
        end else if (i_ctl.commit) begin
            r_acc <= i_ctl.clear ? 32'd0 : result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= cfga_pkg::unpack(i_win);
            r_b <= cfga_pkg::unpack(i_grad);
        end
        r_s1_mp <= r_a.man * r_b.man;
        r_s1_pe <= r_a.exp + r_b.exp - 13'sd315;
        r_s1_ps <= ps;
        r_s1_spec <= spec;
        r_s1_sval <= sval;
        r_s1_czero <= uc.zero;

        r_s2_r <= n_r;
        r_s2_ee <= n_ee;
        r_s2_rs <= n_rs;
        r_s2_zero <= !r_s1_czero && (n_r == 64'd0);
        r_s2_spec <= r_s1_spec;
        r_s2_sval <= r_s1_sval;

        r_s3_r <= r_s2_r;
        r_s3_s <= n_s;
        r_s3_bexp <= bexp;
        r_s3_ovf <= (bexp >= 13'sd255);
        r_s3_rs <= r_s2_rs;
        r_s3_zero <= r_s2_zero;
        r_s3_spec <= r_s2_spec;
        r_s3_sval <= r_s2_sval;
    end

endmodule
`default_nettype wire

[hdl/conv3x3_filter_gradient_accumulator.sv]
// 3x3 filter gradient accumulator: nine fma lanes and the result register
// a new item is accepted only once the previous item's accumulate loop in each lane
// (multiply, align-add, normalize, round) reaches its commit
// synchronous active-low reset clears all tap sums to +0 and empties the output
// depends on cfga_pkg and cfga_lane
`timescale 1ns / 1ps
`default_nettype none
module conv3x3_filter_gradient_accumulator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_win_r0c0,
    input  wire logic [31:0] i_win_r0c1,
    input  wire logic [31:0] i_win_r0c2,
    input  wire logic [31:0] i_win_r1c0,
    input  wire logic [31:0] i_win_r1c1,
    input  wire logic [31:0] i_win_r1c2,
    input  wire logic [31:0] i_win_r2c0,
    input  wire logic [31:0] i_win_r2c1,
    input  wire logic [31:0] i_win_r2c2,
    input  wire logic [31:0] i_grad_value,
    input  wire logic        i_final_item,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_kgrad_r0c0,
    output logic [31:0]      o_kgrad_r0c1,
    output logic [31:0]      o_kgrad_r0c2,
    output logic [31:0]      o_kgrad_r1c0,
    output logic [31:0]      o_kgrad_r1c1,
    output logic [31:0]      o_kgrad_r1c2,
    output logic [31:0]      o_kgrad_r2c0,
    output logic [31:0]      o_kgrad_r2c1,
    output logic [31:0]      o_kgrad_r2c2
);

    logic                r_busy, r_final, r_out_valid;
    logic [1:0]          r_ph;
    logic [31:0]         r_kgrad [cfga_pkg::TapCount];
    logic [31:0]         win [cfga_pkg::TapCount];
    logic [31:0]         sums [cfga_pkg::TapCount];
    logic                accept, commit;
    cfga_pkg::t_lane_ctl ctl;

    assign win[0] = i_win_r0c0;
    assign win[1] = i_win_r0c1;
    assign win[2] = i_win_r0c2;
    assign win[3] = i_win_r1c0;
    assign win[4] = i_win_r1c1;
    assign win[5] = i_win_r1c2;
    assign win[6] = i_win_r2c0;
    assign win[7] = i_win_r2c1;
    assign win[8] = i_win_r2c2;

    assign commit = r_busy && (r_ph == 2'd3);
    // a final item waits until the result register is sure to be free
    assign o_in_stall = (r_busy && !commit) ||
                        (i_final_item && (r_out_valid || (r_busy && r_final)));
    assign accept = i_in_valid && !o_in_stall;

    assign ctl.load = accept;
    assign ctl.commit = commit;
    assign ctl.clear = r_final;

    for (genvar g = 0; g < cfga_pkg::TapCount; g++) begin : g_lane
        cfga_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_win   (win[g]),
            .i_grad  (i_grad_value),
            .o_sum   (sums[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph <= 2'd0;
            r_final <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_ph <= 2'd0;
                r_final <= i_final_item;
            end else if (r_busy) begin
                r_ph <= r_ph + 2'd1;
                if (commit) begin
                    r_busy <= 1'b0;
                end
            end
            if (commit && r_final) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && r_final) begin
            r_kgrad <= sums;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kgrad_r0c0 = r_kgrad[0];
    assign o_kgrad_r0c1 = r_kgrad[1];
    assign o_kgrad_r0c2 = r_kgrad[2];
    assign o_kgrad_r1c0 = r_kgrad[3];
    assign o_kgrad_r1c1 = r_kgrad[4];
    assign o_kgrad_r1c2 = r_kgrad[5];
    assign o_kgrad_r2c0 = r_kgrad[6];
    assign o_kgrad_r2c1 = r_kgrad[7];
    assign o_kgrad_r2c2 = r_kgrad[8];

endmodule
`default_nettype wire

[verif/tb_conv3x3_filter_gradient_accumulator.sv]
// testbench for the 3x3 filter gradient accumulator: directed table, then random items
// self-checking against an in-bench binary32 fma accumulate model; depends on the rtl only
`timescale 1ns / 1ps
module tb_conv3x3_filter_gradient_accumulator;

    localparam int NumTaps = 9;
    localparam int RandItems = 1000;
    localparam int WatchLimit = 3000;
    localparam int LongHold = 200;
    localparam logic [31:0] F32Qnan = 32'h7FC00000;
    localparam logic [31:0] F32Inf = 32'h7F800000;
    localparam logic [31:0] F32One = 32'h3F800000;
    localparam logic [31:0] F32NegOne = 32'hBF800000;
    localparam logic [31:0] F32Max = 32'h7F7FFFFF;

    typedef logic [NumTaps-1:0][31:0] t_taps;

    typedef struct {
        logic [31:0] win;
        logic [31:0] grad;
        logic        fin;
        logic        typed;
        logic [31:0] sum;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] win_q [NumTaps];
    logic [31:0] i_grad_value;
    logic        i_final_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_taps       kgrad;

    t_taps       sums_model;
    t_taps       kgrad_expected [$];
    int          mismatches;
    int          items_in;
    int          results_out;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_request;
    t_row        dir_rows [$];

    conv3x3_filter_gradient_accumulator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_win_r0c0  (win_q[0]),
        .i_win_r0c1  (win_q[1]),
        .i_win_r0c2  (win_q[2]),
        .i_win_r1c0  (win_q[3]),
        .i_win_r1c1  (win_q[4]),
        .i_win_r1c2  (win_q[5]),
        .i_win_r2c0  (win_q[6]),
        .i_win_r2c1  (win_q[7]),
        .i_win_r2c2  (win_q[8]),
        .i_grad_value(i_grad_value),
        .i_final_item(i_final_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kgrad_r0c0(kgrad[0]),
        .o_kgrad_r0c1(kgrad[1]),
        .o_kgrad_r0c2(kgrad[2]),
        .o_kgrad_r1c0(kgrad[3]),
        .o_kgrad_r1c1(kgrad[4]),
        .o_kgrad_r1c2(kgrad[5]),
        .o_kgrad_r2c0(kgrad[6]),
        .o_kgrad_r2c1(kgrad[7]),
        .o_kgrad_r2c2(kgrad[8])
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic bit f32_is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic bit f32_is_inf(input logic [31:0] x);
        return x[30:0] == F32Inf[30:0];
    endfunction

    function automatic bit f32_is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    // nonzero finite value as mant * 2^(ex - 150), mant bit 23 set
    function automatic void f32_split(input logic [31:0] x, output logic [23:0] mant,
                                      output int ex);
        logic [23:0] f;
        int          k;
        f = {1'b0, x[22:0]};
        k = 1;
        if (x[30:23] == 8'd0) begin
            while (!f[23]) begin
                f = f << 1;
                k--;
            end
            mant = f;
            ex = k;
        end else begin
            mant = {1'b1, x[22:0]};
            ex = int'(x[30:23]);
        end
    endfunction

    function automatic logic [63:0] align_right(input logic [63:0] v, input int d);
        if (d <= 0) return v;
        if (d >= 63) return {63'd0, |v};
        return (v >> d) | {63'd0, |(v & ((64'd1 << d) - 64'd1))};
    endfunction

    function automatic logic [31:0] fma_f32(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
        logic        ps;
        logic        rs;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [23:0] mcv;
        int          ea;
        int          eb;
        int          ec;
        int          pe;
        int          ce;
        int          ee;
        int          k;
        int          bexp;
        int          s;
        logic [63:0] mp;
        logic [63:0] mc;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] res;
        ps = a[31] ^ b[31];
        if (f32_is_nan(a) || f32_is_nan(b) || f32_is_nan(c)) return F32Qnan;
        if ((f32_is_inf(a) && f32_is_zero(b)) || (f32_is_inf(b) && f32_is_zero(a)))
            return F32Qnan;
        if (f32_is_inf(a) || f32_is_inf(b)) begin
            if (f32_is_inf(c) && c[31] != ps) return F32Qnan;
            return {ps, F32Inf[30:0]};
        end
        if (f32_is_inf(c)) return c;
        if (f32_is_zero(a) || f32_is_zero(b)) begin
            if (f32_is_zero(c)) return {ps & c[31], 31'd0};
            return c;
        end
        f32_split(a, ma, ea);
        f32_split(b, mb, eb);
        mp = (64'(ma) * 64'(mb)) << 15;
        pe = ea + eb - 315;
        if (f32_is_zero(c)) begin
            r = mp;
            ee = pe;
            rs = ps;
        end else begin
            f32_split(c, mcv, ec);
            mc = 64'(mcv) << 38;
            ce = ec - 188;
            if (pe >= ce) begin
                mc = align_right(mc, pe - ce);
                ee = pe;
            end else begin
                mp = align_right(mp, ce - pe);
                ee = ce;
            end
            if (ps == c[31]) begin
                r = mp + mc;
                rs = ps;
            end else if (mp >= mc) begin
                r = mp - mc;
                rs = ps;
            end else begin
                r = mc - mp;
                rs = c[31];
            end
            if (r == 64'd0) return 32'd0;
        end
        k = 63;
        while (k > 0 && !r[k]) k--;
        bexp = k + ee + 127;
        if (bexp < 1) bexp = 1;
        if (bexp >= 255) return {rs, F32Inf[30:0]};
        s = bexp - 150 - ee;
        if (s <= 0) begin
            if (s < -40) s = -40;
            q = r << (-s);
        end else begin
            if (s > 63) s = 63;
            q = r >> s;
            rem = r & ((64'd1 << s) - 64'd1);
            half = 64'd1 << (s - 1);
            if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        end
        res = (64'(bexp - 1) << 23) + q;
        if (res >= 64'(F32Inf)) return {rs, F32Inf[30:0]};
        return {rs, res[30:0]};
    endfunction

    // updates the tap sums; returns 1 with the emitted gradients on a final item
    function automatic bit accumulate_taps(input logic [31:0] w [NumTaps],
                                           input logic [31:0] g, input logic fin,
                                           output t_taps emitted);
        for (int t = 0; t < NumTaps; t++) sums_model[t] = fma_f32(w[t], g, sums_model[t]);
        emitted = sums_model;
        if (!fin) return 1'b0;
        sums_model = '0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] rand_f32();
        logic s;
        s = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 63))
            0, 1: return $urandom();
            2: return {s, 31'd0};
            3: return {s, F32Inf[30:0]};
            4: return {s, 8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
            5: return {s, 8'd0, 23'($urandom())};
            6: return {s, 8'($urandom_range(245, 254)), 23'($urandom())};
            7: return {s, 8'($urandom_range(1, 12)), 23'($urandom())};
            default: return {s, 8'($urandom_range(100, 150)), 23'($urandom())};
        endcase
    endfunction

    task automatic send_item(input logic [31:0] w [NumTaps], input logic [31:0] g,
                             input logic fin, input bit typed, input t_taps typed_sum);
        t_taps emitted;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        for (int t = 0; t < NumTaps; t++) win_q[t] <= w[t];
        i_grad_value <= g;
        i_final_item <= fin;
        do @(posedge i_clk); while (o_in_stall);
        items_in++;
        if (accumulate_taps(w, g, fin, emitted)) kgrad_expected.push_back(typed ? typed_sum : emitted);
        @(negedge i_clk);
    endtask

    function automatic void add_row(input logic [31:0] w, input logic [31:0] g, input logic fin,
                                    input logic typed, input logic [31:0] sum);
        t_row row;
        row.win = w;
        row.grad = g;
        row.fin = fin;
        row.typed = typed;
        row.sum = sum;
        dir_rows.push_back(row);
    endfunction

    // receiver: random stall per phase, plus one long hold-off
    initial begin
        int held;
        i_out_stall = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_stall <= 1'b1;
                for (held = 1; held < LongHold; held++) @(negedge i_clk);
                hold_request = 1'b0;
            end
            i_out_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_out++;
            if (kgrad_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item: %h", kgrad);
            end else begin
                for (int t = 0; t < NumTaps; t++) begin
                    if (kgrad[t] !== kgrad_expected[0][t]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("tap %0d mismatch: expected %h actual %h", t,
                                     kgrad_expected[0][t], kgrad[t]);
                    end
                end
                void'(kgrad_expected.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchLimit) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("[conv3x3_filter_gradient_accumulator] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] w [NumTaps];
        t_taps       typed_sum;
        int          drained;
        mismatches = 0;
        items_in = 0;
        results_out = 0;
        idle_cycles = 0;
        hold_request = 1'b0;
        send_idle_pct = 21;
        recv_stall_pct = 62;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        for (int t = 0; t < NumTaps; t++) win_q[t] = '0;
        i_grad_value = '0;
        i_final_item = 1'b0;
        sums_model = '0;

        add_row(32'd0, 32'd0, 1'b1, 1'b1, 32'd0);
        add_row(F32One, F32One, 1'b1, 1'b1, F32One);
        add_row(F32Inf, 32'd0, 1'b1, 1'b1, F32Qnan);
        add_row(32'h7FFFFFFF, F32One, 1'b1, 1'b1, F32Qnan);
        add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, F32Qnan);
        add_row(F32Max, F32Max, 1'b1, 1'b1, F32Inf);
        add_row({1'b1, F32Max[30:0]}, F32Max, 1'b1, 1'b1, 32'hFF800000);
        add_row(32'h00000001, 32'h40000000, 1'b1, 1'b1, 32'h00000002);
        add_row(F32One, F32One, 1'b0, 1'b0, 32'd0);
        add_row(F32NegOne, F32One, 1'b1, 1'b1, 32'd0);
        add_row(F32Inf, F32One, 1'b0, 1'b0, 32'd0);
        add_row(F32Inf, F32NegOne, 1'b1, 1'b1, F32Qnan);
        add_row(32'h80000001, 32'h00000001, 1'b0, 1'b0, 32'd0);
        add_row(32'h80000000, 32'd0, 1'b1, 1'b0, 32'd0);
        add_row(32'h007FFFFF, 32'h3F000000, 1'b0, 1'b0, 32'd0);
        add_row(32'h00800000, 32'hBF000001, 1'b1, 1'b0, 32'd0);
        add_row(32'h4B800000, F32One, 1'b0, 1'b0, 32'd0);
        add_row(F32One, 32'h3F000000, 1'b0, 1'b0, 32'd0);
        add_row(F32One, 32'h3F000001, 1'b1, 1'b0, 32'd0);
        add_row(32'h7F000000, 32'h40000000, 1'b1, 1'b1, F32Inf);
        add_row(32'hFFFFFFFF, 32'h00000000, 1'b1, 1'b1, F32Qnan);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            for (int t = 0; t < NumTaps; t++) begin
                w[t] = dir_rows[i].win;
                typed_sum[t] = dir_rows[i].sum;
            end
            send_item(w, dir_rows[i].grad, dir_rows[i].fin, dir_rows[i].typed, typed_sum);
        end

        for (int n = 0; n < RandItems; n++) begin
            if (n == RandItems / 3) begin
                send_idle_pct = 62;
                recv_stall_pct = 21;
            end
            if (n == 2 * RandItems / 3) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                hold_request = 1'b1;
            end
            if (n == RandItems / 2) begin
                i_in_valid <= 1'b0;
                do @(negedge i_clk); while (kgrad_expected.size() != 0);
            end
            for (int t = 0; t < NumTaps; t++) w[t] = rand_f32();
            send_item(w, rand_f32(), $urandom_range(0, 7) == 0, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        drained = 0;
        while (kgrad_expected.size() != 0) @(negedge i_clk);
        while (drained < 20) begin
            @(negedge i_clk);
            drained++;
        end

        $display("sent %0d items (directed specials and random sums), checked %0d results",
                 items_in, results_out);
        if (mismatches == 0 && kgrad_expected.size() == 0) begin
            $display("[conv3x3_filter_gradient_accumulator] OK");
        end else begin
            $display("mismatches: %0d, results outstanding: %0d", mismatches,
                     kgrad_expected.size());
            $display("[conv3x3_filter_gradient_accumulator] ERROR");
        end
        $finish;
    end

endmodule
